// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk and disabled
// while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge out of reset
`define ASSERT_AT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds at a rising clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// File: design/ccot_pkg.sv
// ---------------------------------------------------------------------------
// ccot_pkg
// Widths, codes, reset values and shared types of the coulomb counter with
// OCV table lookup.
// ---------------------------------------------------------------------------
package ccot_pkg;

    // OCV table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int TIDX_W      = $clog2(TABLE_DEPTH);

    // Field widths
    localparam int CHARGE_W  = 48;
    localparam int FULL_W    = 40;
    localparam int BASE_W    = 8;
    localparam int USED_W    = 9;
    localparam int OP_W      = 2;
    localparam int VOLT_W    = 16;
    localparam int CUR_W     = 22;
    localparam int MS_W      = 16;
    localparam int PCT_W     = 14;
    localparam int SOC_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Scale factors: hundredths of percent and half percent per full charge
    localparam int PCT_DIVISOR      = 10000;
    localparam int HALF_PCT_DIVISOR = 200;
    localparam int SOC_SAT          = 20000;
    localparam int SCALE_W          = 14;

    // Multiplier factor for charge resets: table step index or percent
    localparam int FACT_W = (PCT_W > BASE_W + 1) ? PCT_W : BASE_W + 1;

    // Integrate product: (last + present current) times milliseconds
    localparam int INT_PW = CUR_W + MS_W + 2;

    // Shared divider: dividend covers |charge| times the percent scale
    localparam int DIV_NW    = CHARGE_W + SCALE_W;
    localparam int DIV_DW    = FULL_W;
    localparam int DIV_CNT_W = $clog2(DIV_NW);

    // Charge range and reset values
    localparam logic signed [CHARGE_W-1:0] CHARGE_MAX = {1'b0, {(CHARGE_W-1){1'b1}}};
    localparam logic signed [CHARGE_W-1:0] CHARGE_MIN = {1'b1, {(CHARGE_W-1){1'b0}}};
    localparam logic signed [CHARGE_W-1:0] CHARGE_RESET = CHARGE_W'(-1000000);
    localparam logic [FULL_W-1:0] FULL_RESET = 40'd21240000000;
    localparam logic [BASE_W-1:0] BASE_RESET = '0;
    localparam logic [USED_W-1:0] USED_RESET = 9'd201;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD     = 2'd0,
        OP_INTEG    = 2'd1,
        OP_VOLT_RST = 2'd2,
        OP_PCT_RST  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL = 2'd0,
        CFG_BASE = 2'd1,
        CFG_USED = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_INT_MUL,
        S_INT_ADD,
        S_WALK,
        S_RST_MUL,
        S_RST_DIV,
        S_RST_WAIT,
        S_SOC_MUL,
        S_SOC_DIV,
        S_SOC_WAIT,
        S_OCV_MUL,
        S_OCV_DIV,
        S_OCV_WAIT,
        S_OCV_RD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quotient;
        logic [DIV_DW-1:0] remainder;
    } t_div_rsp;

endpackage

// File: design/ccot_div.sv
// ---------------------------------------------------------------------------
// ccot_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse
// loads the operands; done pulses when the last step is registered, and the
// quotient and remainder hold until the next start.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ccot_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ccot_pkg::t_div_req i_req,
    output ccot_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [ccot_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [ccot_pkg::DIV_NW-1:0]    r_quo;
    logic [ccot_pkg::DIV_DW-1:0]    r_rem;
    logic [ccot_pkg::DIV_DW-1:0]    r_dvs;

    logic [ccot_pkg::DIV_DW:0] rem_sh;
    logic [ccot_pkg::DIV_DW:0] rem_sub;
    logic                      rem_ge;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb begin
        rem_sh  = {r_rem, r_quo[ccot_pkg::DIV_NW-1]};
        rem_ge  = (rem_sh >= {1'b0, r_dvs});
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    // Step counter and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= ccot_pkg::DIV_CNT_W'(ccot_pkg::DIV_NW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= rem_ge ? rem_sub[ccot_pkg::DIV_DW-1:0] : rem_sh[ccot_pkg::DIV_DW-1:0];
            r_quo <= {r_quo[ccot_pkg::DIV_NW-2:0], rem_ge};
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

    `ASSERT_AT(a_div_start_idle, i_req.start |-> !r_busy, "divider started while busy")
    `ASSERT_AT(a_div_done_pulse, r_done |=> !r_done, "divider done held past one cycle")
    `ASSERT_NEVER(a_div_zero_divisor, r_busy && (r_dvs == '0), "divider running on zero")

endmodule

// File: design/coulomb_counter_ocv_table_unit.sv
// ---------------------------------------------------------------------------
// coulomb_counter_ocv_table_unit
// Coulomb-counting state-of-charge tracker with an OCV table in half-percent
// steps. Each request loads a table entry, integrates current, or resets the
// charge from a cell voltage or a percent, and returns one result.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-----------------------------
//   in      | to block  | i_in_valid / o_in_stall | opcode, index, voltage,
//           |           |                        | current, elapsed, percent
//   out     | from block| o_out_valid / i_out_stall| charge, soc, ocv, corrupt
//   cfg     | to block  | i_cfg_valid / o_cfg_ready| register index, data
//
// One request at a time. The shared divider (62 steps, one quotient bit per
// cycle) runs the charge-reset, SOC and OCV divisions; the voltage reset adds
// a walk of one table entry per cycle on the table read port. A negative charge
// skips the OCV division. Reset is synchronous; the table holds its contents
// until written. A stalled result waits in the output register while the next
// request is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module coulomb_counter_ocv_table_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ccot_pkg::OP_W-1:0]           i_opcode,
    input  logic [ccot_pkg::TIDX_W-1:0]         i_table_index,
    input  logic [ccot_pkg::VOLT_W-1:0]         i_voltage_tenth_mv,
    input  logic signed [ccot_pkg::CUR_W-1:0]   i_current_ma,
    input  logic [ccot_pkg::MS_W-1:0]           i_elapsed_ms,
    input  logic [ccot_pkg::PCT_W-1:0]          i_set_pct_hundredths,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ccot_pkg::CHARGE_W-1:0] o_charge_uc,
    output logic signed [ccot_pkg::SOC_W-1:0]   o_soc_hundredths,
    output logic [ccot_pkg::VOLT_W-1:0]         o_ocv_tenth_mv,
    output logic                                o_corrupt,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ccot_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ccot_pkg::FULL_W-1:0]         i_cfg_data
);

    ccot_pkg::t_state r_state;
    ccot_pkg::t_state n_state;

    // configuration registers
    logic [ccot_pkg::FULL_W-1:0] r_full;
    logic [ccot_pkg::BASE_W-1:0] r_base;
    logic [ccot_pkg::USED_W-1:0] r_used;

    // tracker state
    logic signed [ccot_pkg::CHARGE_W-1:0] r_charge;
    logic signed [ccot_pkg::CUR_W-1:0]    r_last;
    logic                                 r_flag;
    logic [ccot_pkg::TIDX_W-1:0]          r_walk;

    // latched request
    ccot_pkg::t_opcode                  r_op;
    logic [ccot_pkg::TIDX_W-1:0]        r_tab_idx;
    logic [ccot_pkg::VOLT_W-1:0]        r_volt;
    logic signed [ccot_pkg::CUR_W-1:0]  r_cur;
    logic [ccot_pkg::MS_W-1:0]          r_ms;
    logic [ccot_pkg::PCT_W-1:0]         r_pct;

    // working registers
    logic signed [ccot_pkg::INT_PW-1:0] r_iprod;
    logic [ccot_pkg::DIV_NW-1:0]        r_mprod;
    logic                               r_neg;
    logic signed [ccot_pkg::SOC_W-1:0]  r_soc;
    logic [ccot_pkg::TIDX_W-1:0]        r_tidx;

    // OCV table memory
    logic [ccot_pkg::VOLT_W-1:0] r_ocv_mem [ccot_pkg::TABLE_DEPTH];
    logic [ccot_pkg::VOLT_W-1:0] r_rd_data;
    logic [ccot_pkg::TIDX_W-1:0] mem_raddr;
    logic                        mem_we;

    // output register
    logic                                 r_out_valid;
    logic signed [ccot_pkg::CHARGE_W-1:0] r_out_charge;
    logic signed [ccot_pkg::SOC_W-1:0]    r_out_soc;
    logic [ccot_pkg::VOLT_W-1:0]          r_out_ocv;
    logic                                 r_out_corrupt;

    ccot_pkg::t_div_req div_req;
    ccot_pkg::t_div_rsp div_rsp;

    logic                                          in_acc;
    logic                                          cfg_acc;
    logic                                          out_load;
    logic [ccot_pkg::FULL_W-1:0]                   full_eff;
    logic [ccot_pkg::TIDX_W-1:0]                   last_idx;
    logic                                          walk_hit;
    logic signed [ccot_pkg::CUR_W:0]               cur_sum;
    logic signed [ccot_pkg::INT_PW-1:0]            int_prod;
    logic signed [ccot_pkg::INT_PW-1:0]            int_delta;
    logic signed [ccot_pkg::CHARGE_W:0]            acc_sum;
    logic signed [ccot_pkg::CHARGE_W-1:0]          int_next;
    logic [ccot_pkg::FACT_W-1:0]                   rst_fact;
    logic [ccot_pkg::FULL_W+ccot_pkg::FACT_W-1:0]  rst_prod;
    logic signed [ccot_pkg::CHARGE_W-1:0]          rst_next;
    logic [ccot_pkg::CHARGE_W-1:0]                 charge_mag;
    logic [ccot_pkg::DIV_NW-1:0]                   soc_dividend;
    logic [ccot_pkg::DIV_NW-1:0]                   ocv_dividend;
    logic [ccot_pkg::DIV_NW-1:0]                   q_adj;
    logic signed [ccot_pkg::SOC_W-1:0]             soc_value;
    logic [ccot_pkg::DIV_NW-1:0]                   ocv_step;
    logic [ccot_pkg::TIDX_W-1:0]                   ocv_idx;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ccot_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == ccot_pkg::S_IDLE);
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_load    = (r_state == ccot_pkg::S_OUT) && (!r_out_valid || !i_out_stall);

    // Treat a zero full charge as one and clip the entry count to the table
    always_comb begin
        full_eff = (r_full == '0) ? ccot_pkg::FULL_W'(1) : r_full;
        if (r_used == '0) begin
            last_idx = '0;
        end else if (r_used > ccot_pkg::USED_W'(ccot_pkg::TABLE_DEPTH)) begin
            last_idx = ccot_pkg::TIDX_W'(ccot_pkg::TABLE_DEPTH - 1);
        end else begin
            last_idx = ccot_pkg::TIDX_W'(r_used - 1'b1);
        end
    end

    // Voltage walk stops at the first entry at or above the cell voltage, or at the last entry in use
    assign walk_hit = (r_volt <= r_rd_data) || (r_walk == last_idx);

    // Trapezoid step: floor of half the product, then saturate the charge
    always_comb begin
        cur_sum   = (ccot_pkg::CUR_W+1)'(r_last) + (ccot_pkg::CUR_W+1)'(r_cur);
        int_prod  = ccot_pkg::INT_PW'(cur_sum) * ccot_pkg::INT_PW'($signed({1'b0, r_ms}));
        int_delta = r_iprod >>> 1;
        acc_sum   = (ccot_pkg::CHARGE_W+1)'(r_charge) + (ccot_pkg::CHARGE_W+1)'(int_delta);
        if (acc_sum > (ccot_pkg::CHARGE_W+1)'(ccot_pkg::CHARGE_MAX)) begin
            int_next = ccot_pkg::CHARGE_MAX;
        end else if (acc_sum < (ccot_pkg::CHARGE_W+1)'(ccot_pkg::CHARGE_MIN)) begin
            int_next = ccot_pkg::CHARGE_MIN;
        end else begin
            int_next = ccot_pkg::CHARGE_W'(acc_sum);
        end
    end

    // Charge reset: full charge times table step or percent, then divide
    always_comb begin
        if (r_op == ccot_pkg::OP_VOLT_RST) begin
            rst_fact = ccot_pkg::FACT_W'((ccot_pkg::BASE_W+1)'(r_base)
                                         + (ccot_pkg::BASE_W+1)'(r_walk));
        end else begin
            rst_fact = ccot_pkg::FACT_W'(r_pct);
        end
        rst_prod = (ccot_pkg::FULL_W+ccot_pkg::FACT_W)'(full_eff)
                 * (ccot_pkg::FULL_W+ccot_pkg::FACT_W)'(rst_fact);
        if (div_rsp.quotient > ccot_pkg::DIV_NW'(ccot_pkg::CHARGE_MAX)) begin
            rst_next = ccot_pkg::CHARGE_MAX;
        end else begin
            rst_next = ccot_pkg::CHARGE_W'(div_rsp.quotient);
        end
    end

    // SOC: floor of charge times 10000 over full charge, saturated
    always_comb begin
        charge_mag   = r_charge[ccot_pkg::CHARGE_W-1] ? ccot_pkg::CHARGE_W'(-r_charge)
                                                      : ccot_pkg::CHARGE_W'(r_charge);
        soc_dividend = ccot_pkg::DIV_NW'(charge_mag) * ccot_pkg::DIV_NW'(ccot_pkg::PCT_DIVISOR);
        q_adj        = div_rsp.quotient + ccot_pkg::DIV_NW'(|div_rsp.remainder);
        if (!r_neg) begin
            if (div_rsp.quotient >= ccot_pkg::DIV_NW'(ccot_pkg::SOC_SAT)) begin
                soc_value = ccot_pkg::SOC_W'(ccot_pkg::SOC_SAT);
            end else begin
                soc_value = ccot_pkg::SOC_W'(div_rsp.quotient);
            end
        end else begin
            if (q_adj >= ccot_pkg::DIV_NW'(ccot_pkg::SOC_SAT)) begin
                soc_value = ccot_pkg::SOC_W'(-ccot_pkg::SOC_SAT);
            end else begin
                soc_value = ccot_pkg::SOC_W'(0) - ccot_pkg::SOC_W'(q_adj);
            end
        end
    end

    // OCV entry: first step at or above ceil(200 * charge / full)
    always_comb begin
        ocv_dividend = ccot_pkg::DIV_NW'(r_charge) * ccot_pkg::DIV_NW'(ccot_pkg::HALF_PCT_DIVISOR)
                     + ccot_pkg::DIV_NW'(full_eff) - ccot_pkg::DIV_NW'(1);
        ocv_step     = div_rsp.quotient - ccot_pkg::DIV_NW'(r_base);
        if (div_rsp.quotient <= ccot_pkg::DIV_NW'(r_base)) begin
            ocv_idx = '0;
        end else if (ocv_step > ccot_pkg::DIV_NW'(last_idx)) begin
            ocv_idx = last_idx;
        end else begin
            ocv_idx = ccot_pkg::TIDX_W'(ocv_step);
        end
    end

    // Next state, table port and divider request
    always_comb begin
        n_state          = r_state;
        mem_raddr        = r_tidx;
        mem_we           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_mprod;
        div_req.divisor  = full_eff;
        unique case (r_state)
            ccot_pkg::S_IDLE: begin
                mem_raddr = '0;
                if (in_acc) begin
                    unique case (ccot_pkg::t_opcode'(i_opcode))
                        ccot_pkg::OP_LOAD:     n_state = ccot_pkg::S_LOAD;
                        ccot_pkg::OP_INTEG:    n_state = ccot_pkg::S_INT_MUL;
                        ccot_pkg::OP_VOLT_RST: n_state = ccot_pkg::S_WALK;
                        ccot_pkg::OP_PCT_RST:  n_state = ccot_pkg::S_RST_MUL;
                        default:               n_state = ccot_pkg::S_IDLE;
                    endcase
                end
            end
            ccot_pkg::S_LOAD: begin
                mem_we  = 1'b1;
                n_state = ccot_pkg::S_SOC_MUL;
            end
            ccot_pkg::S_INT_MUL: n_state = ccot_pkg::S_INT_ADD;
            ccot_pkg::S_INT_ADD: n_state = ccot_pkg::S_SOC_MUL;
            ccot_pkg::S_WALK: begin
                if (walk_hit) begin
                    n_state = ccot_pkg::S_RST_MUL;
                end else begin
                    mem_raddr = r_walk + 1'b1;
                end
            end
            ccot_pkg::S_RST_MUL: n_state = ccot_pkg::S_RST_DIV;
            ccot_pkg::S_RST_DIV: begin
                div_req.start   = 1'b1;
                div_req.divisor = (r_op == ccot_pkg::OP_VOLT_RST)
                                ? ccot_pkg::DIV_DW'(ccot_pkg::HALF_PCT_DIVISOR)
                                : ccot_pkg::DIV_DW'(ccot_pkg::PCT_DIVISOR);
                n_state         = ccot_pkg::S_RST_WAIT;
            end
            ccot_pkg::S_RST_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ccot_pkg::S_SOC_MUL;
                end
            end
            ccot_pkg::S_SOC_MUL: n_state = ccot_pkg::S_SOC_DIV;
            ccot_pkg::S_SOC_DIV: begin
                div_req.start = 1'b1;
                n_state       = ccot_pkg::S_SOC_WAIT;
            end
            ccot_pkg::S_SOC_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ccot_pkg::S_OCV_MUL;
                end
            end
            ccot_pkg::S_OCV_MUL: begin
                n_state = r_charge[ccot_pkg::CHARGE_W-1] ? ccot_pkg::S_OCV_RD
                                                         : ccot_pkg::S_OCV_DIV;
            end
            ccot_pkg::S_OCV_DIV: begin
                div_req.start = 1'b1;
                n_state       = ccot_pkg::S_OCV_WAIT;
            end
            ccot_pkg::S_OCV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = ccot_pkg::S_OCV_RD;
                end
            end
            ccot_pkg::S_OCV_RD: n_state = ccot_pkg::S_OUT;
            ccot_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = ccot_pkg::S_IDLE;
                end
            end
            default: n_state = ccot_pkg::S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccot_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes; an index past the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= ccot_pkg::FULL_RESET;
            r_base <= ccot_pkg::BASE_RESET;
            r_used <= ccot_pkg::USED_RESET;
        end else if (cfg_acc) begin
            unique case (i_cfg_index)
                ccot_pkg::CFG_FULL: r_full <= i_cfg_data;
                ccot_pkg::CFG_BASE: r_base <= i_cfg_data[ccot_pkg::BASE_W-1:0];
                ccot_pkg::CFG_USED: r_used <= i_cfg_data[ccot_pkg::USED_W-1:0];
                default: ;
            endcase
        end
    end

    // Charge, last current, corrupt flag and walk pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge <= ccot_pkg::CHARGE_RESET;
            r_last   <= '0;
            r_flag   <= 1'b1;
            r_walk   <= '0;
        end else begin
            unique case (r_state)
                ccot_pkg::S_IDLE: r_walk <= '0;
                ccot_pkg::S_INT_ADD: begin
                    r_charge <= int_next;
                    r_last   <= r_cur;
                end
                ccot_pkg::S_WALK: begin
                    if (!walk_hit) begin
                        r_walk <= r_walk + 1'b1;
                    end
                end
                ccot_pkg::S_RST_WAIT: begin
                    if (div_rsp.done) begin
                        r_charge <= rst_next;
                        r_flag   <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Request fields and working products
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op      <= ccot_pkg::t_opcode'(i_opcode);
            r_tab_idx <= i_table_index;
            r_volt    <= i_voltage_tenth_mv;
            r_cur     <= i_current_ma;
            r_ms      <= i_elapsed_ms;
            r_pct     <= i_set_pct_hundredths;
        end
        unique case (r_state)
            ccot_pkg::S_INT_MUL: r_iprod <= int_prod;
            ccot_pkg::S_RST_MUL: r_mprod <= ccot_pkg::DIV_NW'(rst_prod);
            ccot_pkg::S_SOC_MUL: begin
                r_mprod <= soc_dividend;
                r_neg   <= r_charge[ccot_pkg::CHARGE_W-1];
            end
            ccot_pkg::S_SOC_WAIT: begin
                if (div_rsp.done) begin
                    r_soc <= soc_value;
                end
            end
            ccot_pkg::S_OCV_MUL: begin
                r_mprod <= ocv_dividend;
                if (r_charge[ccot_pkg::CHARGE_W-1]) begin
                    r_tidx <= '0;
                end
            end
            ccot_pkg::S_OCV_WAIT: begin
                if (div_rsp.done) begin
                    r_tidx <= ocv_idx;
                end
            end
            default: ;
        endcase
    end

    // OCV table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ocv_mem[r_tab_idx] <= r_volt;
        end
        r_rd_data <= r_ocv_mem[mem_raddr];
    end

    // Output register: hold a stalled result, load the next when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_charge  <= r_charge;
            r_out_soc     <= r_soc;
            r_out_ocv     <= r_rd_data;
            r_out_corrupt <= r_flag;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_charge_uc      = r_out_charge;
    assign o_soc_hundredths = r_out_soc;
    assign o_ocv_tenth_mv   = r_out_ocv;
    assign o_corrupt        = r_out_corrupt;

    ccot_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    `ASSERT_AT(a_accept_busy, in_acc |=> o_in_stall, "request taken but block not busy")
    `ASSERT_NEVER(a_walk_bound, (r_state == ccot_pkg::S_WALK) && (r_walk > last_idx), "walk past last entry")
    `ASSERT_AT(a_ocv_idx_bound, (r_state == ccot_pkg::S_OUT) |-> (r_tidx <= last_idx), "OCV index past last entry")

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: coulomb counter with OCV table lookup
// Fills the OCV table, runs a short directed list over the field extremes,
// every opcode, exact table boundaries and saturated percentages, then
// random requests under several register settings and idling patterns, and
// finally drives the charge into both saturation limits. A clocked driver
// feeds requests from a queue, a clocked monitor checks each result field by
// field against an in-bench tracker of charge, current, flag and table.
// ---------------------------------------------------------------------------
module tb;
    import ccot_pkg::*;

    localparam logic signed [CUR_W-1:0] CUR_HI = {1'b0, {(CUR_W-1){1'b1}}};
    localparam logic signed [CUR_W-1:0] CUR_LO = {1'b1, {(CUR_W-1){1'b0}}};
    localparam int RAMP_STEPS = 1040;

    typedef struct packed {
        t_opcode                   op;
        logic [TIDX_W-1:0]         idx;
        logic [VOLT_W-1:0]         volt;
        logic signed [CUR_W-1:0]   cur;
        logic [MS_W-1:0]           ms;
        logic [PCT_W-1:0]          pct;
        logic                      wait_drain;
    } t_gauge_req;

    typedef struct packed {
        logic signed [CHARGE_W-1:0] charge;
        logic signed [SOC_W-1:0]    soc;
        logic [VOLT_W-1:0]          ocv;
        logic                       corrupt;
    } t_reading;

    // clock, reset and block ports
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic [OP_W-1:0] req_op = '0;
    logic [TIDX_W-1:0] req_idx = '0;
    logic [VOLT_W-1:0] req_volt = '0;
    logic signed [CUR_W-1:0] req_cur = '0;
    logic [MS_W-1:0] req_ms = '0;
    logic [PCT_W-1:0] req_pct = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic signed [CHARGE_W-1:0] rsp_charge;
    logic signed [SOC_W-1:0] rsp_soc;
    logic [VOLT_W-1:0] rsp_ocv;
    logic rsp_corrupt;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FULL_W-1:0] cfg_data = '0;

    // request plan and results still owed by the block
    t_gauge_req gauge_req_q[$];
    t_reading   readings_due_q[$];
    t_gauge_req cur_req;
    t_reading   want;
    t_reading   got;

    // tracker state and its copy of the registers
    longint                 charge_now = -1000000;
    logic signed [CUR_W-1:0] last_cur = '0;
    logic                   untrusted = 1'b1;
    logic [VOLT_W-1:0]      ocv_tbl[TABLE_DEPTH];
    logic [VOLT_W-1:0]      plan_tbl[TABLE_DEPTH];
    logic [FULL_W-1:0]      cfg_full = FULL_RESET;
    logic [BASE_W-1:0]      cfg_base = BASE_RESET;
    logic [USED_W-1:0]      cfg_used = USED_RESET;

    int send_idle_pct = 18;
    int recv_stall_pct = 18;
    int n_accepted = 0;
    int n_checked = 0;
    int n_faults = 0;
    int n_settings = 0;
    int n_pinned_hi = 0;
    int n_pinned_lo = 0;

    coulomb_counter_ocv_table_unit dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (req_valid),
        .o_in_stall          (req_stall),
        .i_opcode            (req_op),
        .i_table_index       (req_idx),
        .i_voltage_tenth_mv  (req_volt),
        .i_current_ma        (req_cur),
        .i_elapsed_ms        (req_ms),
        .i_set_pct_hundredths(req_pct),
        .o_out_valid         (rsp_valid),
        .i_out_stall         (rsp_stall),
        .o_charge_uc         (rsp_charge),
        .o_soc_hundredths    (rsp_soc),
        .o_ocv_tenth_mv      (rsp_ocv),
        .o_corrupt           (rsp_corrupt),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Pin a new charge to the signed charge range
    function automatic longint pin_charge(longint v);
        if (v > longint'(CHARGE_MAX)) return longint'(CHARGE_MAX);
        if (v < longint'(CHARGE_MIN)) return longint'(CHARGE_MIN);
        return v;
    endfunction

    // Apply one request to the tracker and return the reading it produces
    function automatic t_reading advance_gauge(t_gauge_req r);
        longint f;
        longint used;
        longint prod;
        longint q;
        longint rem;
        longint soc;
        int i;
        bit hit;
        t_reading res;
        f = (cfg_full == '0) ? 1 : longint'(cfg_full);
        if (cfg_used == '0) used = 1;
        else if (cfg_used > TABLE_DEPTH) used = TABLE_DEPTH;
        else used = longint'(cfg_used);
        case (r.op)
            OP_LOAD: begin
                ocv_tbl[r.idx] = r.volt;
            end
            OP_INTEG: begin
                // trapezoid, floored
                prod = (longint'(last_cur) + longint'(r.cur)) * longint'(r.ms);
                charge_now = pin_charge(charge_now + (prod >>> 1));
                last_cur = r.cur;
                if (charge_now == longint'(CHARGE_MAX)) n_pinned_hi++;
                if (charge_now == longint'(CHARGE_MIN)) n_pinned_lo++;
            end
            OP_VOLT_RST: begin
                // first entry in use at or above the voltage, else the last one
                i = 0;
                while (i < used && r.volt > ocv_tbl[i]) i++;
                if (i == used) i = used - 1;
                charge_now = pin_charge(f * (longint'(cfg_base) + i) / HALF_PCT_DIVISOR);
                untrusted = 1'b1;
            end
            default: begin
                charge_now = pin_charge(f * longint'(r.pct) / PCT_DIVISOR);
                untrusted = 1'b1;
            end
        endcase
        // floored quotient and remainder of charge over full charge
        q = charge_now / f;
        rem = charge_now % f;
        if (rem < 0) begin
            q--;
            rem += f;
        end
        if (q >= 2) soc = SOC_SAT;
        else if (q < -2) soc = -SOC_SAT;
        else soc = q * PCT_DIVISOR + rem * PCT_DIVISOR / f;
        // walk the table for the first step at or above the state of charge
        i = 0;
        hit = 1'b0;
        while (i < used && !hit) begin
            if (q < 0) hit = 1'b1;
            else if (q >= 3) hit = 1'b0;
            else hit = (longint'(cfg_base) + i) * f >= HALF_PCT_DIVISOR * charge_now;
            if (!hit) i++;
        end
        res.charge = CHARGE_W'(charge_now);
        res.soc = SOC_W'(soc);
        res.ocv = hit ? ocv_tbl[i] : ocv_tbl[used - 1];
        res.corrupt = untrusted;
        return res;
    endfunction

    // Driver: predict each taken request, hold a stalled one, else present the next
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && !req_stall) begin
                readings_due_q.push_back(advance_gauge(cur_req));
                n_accepted++;
            end
            if (!req_valid || !req_stall) begin
                if (gauge_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                    !(gauge_req_q[0].wait_drain && readings_due_q.size() != 0)) begin
                    cur_req = gauge_req_q.pop_front();
                    req_valid <= 1'b1;
                    req_op <= cur_req.op;
                    req_idx <= cur_req.idx;
                    req_volt <= cur_req.volt;
                    req_cur <= cur_req.cur;
                    req_ms <= cur_req.ms;
                    req_pct <= cur_req.pct;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_fault(string what);
        n_faults++;
        if (n_faults <= 10)
            $display("mismatch %0d: %s: charge %0d/%0d soc %0d/%0d ocv %0d/%0d corrupt %0b/%0b",
                     n_faults, what, want.charge, got.charge, want.soc, got.soc,
                     want.ocv, got.ocv, want.corrupt, got.corrupt);
    endtask

    // Monitor: check each taken result against the oldest reading owed
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                got.charge = rsp_charge;
                got.soc = rsp_soc;
                got.ocv = rsp_ocv;
                got.corrupt = rsp_corrupt;
                if (readings_due_q.size() == 0) begin
                    want = 'x;
                    report_fault("result with no request owed (expected/actual)");
                end else begin
                    want = readings_due_q.pop_front();
                    n_checked++;
                    if (got !== want) report_fault("field differs (expected/actual)");
                end
            end
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Queue one request; keep a plan-side copy of the table for targeting voltages
    task automatic plan_request(t_opcode op, int idx, int volt, int cur, int ms, int pct,
                                bit drain);
        t_gauge_req r;
        r.op = op;
        r.idx = TIDX_W'(idx);
        r.volt = VOLT_W'(volt);
        r.cur = CUR_W'(cur);
        r.ms = MS_W'(ms);
        r.pct = PCT_W'(pct);
        r.wait_drain = drain;
        if (op == OP_LOAD) plan_tbl[r.idx] = r.volt;
        gauge_req_q.push_back(r);
    endtask

    task automatic plan_random_request(bit drain);
        int pick;
        int idx;
        int volt;
        int cur;
        int ms;
        int pct;
        pick = $urandom_range(99);
        idx = $urandom_range(255);
        // current: half full range, most of the rest small, a few extremes
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: cur = int'(CUR_HI);
                    1: cur = int'(CUR_LO);
                    2: cur = 0;
                    default: cur = -1;
                endcase
            end
            1, 2, 3, 4: cur = int'($urandom_range(6000)) - 3000;
            default: cur = $urandom();
        endcase
        case ($urandom_range(4))
            0, 1: ms = $urandom_range(200);
            2: ms = $urandom_range(1) ? 65535 : 0;
            default: ms = $urandom_range(65535);
        endcase
        // voltage: half aimed at a table entry or a neighbor
        if ($urandom_range(1))
            volt = int'(plan_tbl[$urandom_range(255)]) + int'($urandom_range(2)) - 1;
        else
            volt = $urandom_range(65535);
        pct = ($urandom_range(4) == 0) ? $urandom_range(16383) : $urandom_range(10000);
        drain = drain || ($urandom_range(99) == 0);
        if (pick < 15) begin
            if ($urandom_range(2) != 0) volt = idx * 256 + $urandom_range(255);
            plan_request(OP_LOAD, idx, volt, cur, ms, pct, drain);
        end else if (pick < 65) begin
            plan_request(OP_INTEG, idx, volt, cur, ms, pct, drain);
        end else if (pick < 82) begin
            plan_request(OP_VOLT_RST, idx, volt, cur, ms, pct, drain);
        end else begin
            plan_request(OP_PCT_RST, idx, volt, cur, ms, pct, drain);
        end
    endtask

    // Wait until no request is pending or owed
    task automatic wait_idle();
        @(negedge clk);
        while (gauge_req_q.size() != 0 || req_valid || readings_due_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [FULL_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FULL: cfg_full = val;
            CFG_BASE: cfg_base = val[BASE_W-1:0];
            CFG_USED: cfg_used = val[USED_W-1:0];
            default: ;
        endcase
    endtask

    // Drain, write all registers, set the idling pattern and queue random requests
    task automatic run_phase(logic [FULL_W-1:0] full, int base, int used, int n,
                             int send_pct, int stall_pct);
        int k;
        wait_idle();
        write_reg(CFG_FULL, full);
        write_reg(CFG_BASE, FULL_W'(base));
        write_reg(CFG_USED, FULL_W'(used));
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        n_settings++;
        for (k = 0; k < n; k++) plan_random_request(k == n / 2);
    endtask

    initial begin
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        n_settings = 1;

        // fill the whole table with a rising curve, entry zero first
        for (k = 0; k < TABLE_DEPTH; k++)
            plan_request(OP_LOAD, k, k * 256 + $urandom_range(255), $urandom(), $urandom(),
                         $urandom(), 1'b0);

        // integrate: zero, extremes, odd negative products
        plan_request(OP_INTEG, 0, 0, 0, 0, 0, 1'b0);
        plan_request(OP_INTEG, 1, 1, int'(CUR_HI), 65535, 1, 1'b0);
        plan_request(OP_INTEG, 2, 2, int'(CUR_LO), 65535, 2, 1'b0);
        plan_request(OP_INTEG, 3, 3, -1, 1, 3, 1'b0);
        // negative charge below twice full: saturated low percentage
        plan_request(OP_PCT_RST, 4, 4, 0, 0, 0, 1'b0);
        plan_request(OP_INTEG, 5, 5, int'(CUR_LO), 65535, 5, 1'b0);
        plan_request(OP_INTEG, 6, 6, 0, 1, 6, 1'b0);
        // percent resets: bounds, above full, an exact table step
        plan_request(OP_PCT_RST, 7, 7, 7, 7, 10000, 1'b0);
        plan_request(OP_PCT_RST, 8, 8, 8, 8, 16383, 1'b0);
        plan_request(OP_PCT_RST, 9, 9, 9, 9, 5000, 1'b0);
        plan_request(OP_PCT_RST, 10, 10, 10, 10, 1, 1'b0);
        // voltage resets: lowest, above every entry, exact entry, just above one
        plan_request(OP_VOLT_RST, 11, 0, 11, 11, 11, 1'b0);
        plan_request(OP_VOLT_RST, 12, 65535, 12, 12, 12, 1'b0);
        plan_request(OP_VOLT_RST, 13, int'(plan_tbl[100]), 13, 13, 13, 1'b0);
        plan_request(OP_VOLT_RST, 14, int'(plan_tbl[100]) + 1, 14, 14, 14, 1'b0);
        // table loads at both ends of index and voltage
        plan_request(OP_LOAD, 0, 0, int'(CUR_HI), 65535, 16383, 1'b0);
        plan_request(OP_LOAD, 255, 65535, int'(CUR_LO), 0, 0, 1'b0);
        plan_request(OP_VOLT_RST, 17, 1, 17, 17, 17, 1'b0);
        plan_request(OP_INTEG, 18, 18, 1, 65535, 18, 1'b0);
        plan_request(OP_INTEG, 19, 19, int'(CUR_HI), 1, 19, 1'b0);

        // random requests over several settings and idling patterns
        run_phase(40'd1, 0, 256, 140, 0, 0);
        run_phase({FULL_W{1'b1}}, 200, 2, 140, 55, 0);
        run_phase(FULL_RESET, 0, 201, 160, 0, 55);
        run_phase('0, 255, 0, 100, 18, 18);
        run_phase(FULL_W'(64'($urandom()) * 10), $urandom_range(200), 511, 160, 55, 0);
        run_phase(40'd5000000000, 37, 97, 150, 0, 55);
        run_phase({8'($urandom_range(255)), 32'($urandom())}, $urandom_range(200),
                  $urandom_range(2, 256), 200, 18, 18);

        // ramp the charge into the upper limit, then the lower one
        run_phase(40'd100000000000, 0, 256, 0, 0, 0);
        plan_request(OP_PCT_RST, 0, 0, 0, 0, 16383, 1'b0);
        for (k = 0; k < RAMP_STEPS; k++)
            plan_request(OP_INTEG, $urandom(), $urandom(), int'(CUR_HI), 65535, $urandom(), 1'b0);
        plan_request(OP_PCT_RST, 0, 0, 0, 0, 0, 1'b0);
        for (k = 0; k < RAMP_STEPS; k++)
            plan_request(OP_INTEG, $urandom(), $urandom(), int'(CUR_LO), 65535, $urandom(), 1'b0);
        plan_request(OP_INTEG, 0, 0, int'(CUR_HI), 100, 0, 1'b0);

        // drain, then wait on for any stray results
        wait_idle();
        repeat (600) @(posedge clk);
        $display("summary: %0d requests under %0d register settings, %0d results checked",
                 n_accepted, n_settings, n_checked);
        $display("summary: charge pinned high %0d and low %0d times, %0d mismatches",
                 n_pinned_hi, n_pinned_lo, n_faults);
        if (n_faults == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // End a hung run
    initial begin
        #40000000;
        $display("tb: errors");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/ccot_pkg.sv
design/ccot_div.sv
design/coulomb_counter_ocv_table_unit.sv
dv/tb.sv
